// ===== src/svcrb_pkg.sv =====
// ----------------------------------------------------------------------------
// svcrb_pkg
// Shared types and constants for the servo channel register block.
// ----------------------------------------------------------------------------
package svcrb_pkg;

  // Operation codes of a request
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_SET_UPPER = 3'd1;
  localparam logic [2:0] OP_SET_LOWER = 3'd2;
  localparam logic [2:0] OP_SET_POS   = 3'd3;
  localparam logic [2:0] OP_ADC       = 3'd4;
  localparam logic [2:0] OP_READ_POS  = 3'd5;
  localparam logic [2:0] OP_READ_ADC  = 3'd6;

  // Configuration register map
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned GAIN_REGS   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END         = 4'd8;

  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned PROD_W   = ADC_W + GAIN_W;
  localparam int unsigned ACC_W    = PROD_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET [GAIN_REGS] =
    '{16'd36179, 16'd36150, 16'd36302, 16'd36904};
  localparam logic [OFFSET_W-1:0] OFFSET_RESET [GAIN_REGS] =
    '{24'd11039841, 24'd11078796, 24'd11071114, 24'd11114900};

  localparam logic [CNT_W-1:0] CNT_IDLE = 8'hFF;
  localparam logic [POS_W-1:0] POS_MAX  = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_MIN  = 16'h0000;
  localparam logic [CNT_W-1:0] ADC_GUARD_TICKS = 8'd5;

  typedef struct packed {
    logic [2:0]       op;
    logic [1:0]       channel;
    logic [POS_W-1:0] value;
    logic [ADC_W-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] read_data;
    logic             relay_on;
    logic             pulses_enabled;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic commit;
  } dp_cmd_t;

endpackage

// ===== src/svcrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// svcrb_ctrl
// Sequencer: accept a request, run the multiply step, then commit.
// ----------------------------------------------------------------------------
module svcrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output svcrb_pkg::dp_cmd_t cmd_o
);
  import svcrb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   mul_q;
  logic   commit_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      busy_q   <= 1'b0;
      mul_q    <= 1'b0;
      commit_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= ST_MUL;
            busy_q  <= 1'b1;
            mul_q   <= 1'b1;
          end
        end
        ST_MUL: begin
          state_q  <= ST_COMMIT;
          mul_q    <= 1'b0;
          commit_q <= 1'b1;
        end
        ST_COMMIT: begin
          state_q  <= ST_IDLE;
          commit_q <= 1'b0;
          busy_q   <= 1'b0;
          done_q   <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign cmd_o.load    = start_i && !busy_q;
  assign cmd_o.mul     = mul_q;
  assign cmd_o.commit  = commit_q;

endmodule

// ===== src/svcrb_dpath.sv =====
// ----------------------------------------------------------------------------
// svcrb_dpath
// Channel state, calibration registers, relay timing and result register.
// ----------------------------------------------------------------------------
module svcrb_dpath #(
  parameter int unsigned CHANNELS        = 4,
  parameter int unsigned RELAY_ON_TICKS  = 10,
  parameter int unsigned RELAY_OFF_TICKS = 100,
  parameter int unsigned GAIN_SHIFT      = 11
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  svcrb_pkg::dp_cmd_t                   cmd_i,
  input  svcrb_pkg::in_item_t                  item_i,
  input  logic                                 cfg_we_i,
  input  logic [svcrb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [svcrb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output svcrb_pkg::out_item_t                 result_o
);
  import svcrb_pkg::*;

  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CNT_W-1:0] ON_TICKS  = CNT_W'(RELAY_ON_TICKS);
  localparam logic [CNT_W-1:0] OFF_TICKS = CNT_W'(RELAY_OFF_TICKS);
  localparam logic [CNT_W-1:0] ADC_LATE  = CNT_W'(RELAY_OFF_TICKS) + ADC_GUARD_TICKS;

  // calibration registers
  logic [GAIN_W-1:0]   gain_q   [GAIN_REGS];
  logic [OFFSET_W-1:0] offset_q [GAIN_REGS];

  // channel state
  logic [POS_W-1:0] lower_q    [CHANNELS];
  logic [POS_W-1:0] upper_q    [CHANNELS];
  logic [POS_W-1:0] target_q   [CHANNELS];
  logic [POS_W-1:0] measured_q [CHANNELS];

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             relay_q, relay_d;
  logic             pulse_q, pulse_d;

  in_item_t         item_q;
  logic [PROD_W-1:0] prod_q;
  out_item_t        result_q;

  logic [CH_IDX_W-1:0] ch_idx;
  logic                present;
  logic [POS_W-1:0]    lo, up, clamp_lo, clamp;
  logic [ACC_W-1:0]    acc, acc_sh;
  logic                wr_lower, wr_upper, wr_target, wr_meas;
  logic [POS_W-1:0]    rd_d;
  logic [CNT_W-1:0]    cnt_inc;

  assign ch_idx  = CH_IDX_W'(item_q.channel);
  assign present = 32'(item_q.channel) < CHANNELS;
  assign lo      = lower_q[ch_idx];
  assign up      = upper_q[ch_idx];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GAIN_REGS; i++) begin
        gain_q[i]   <= GAIN_RESET[i];
        offset_q[i] <= OFFSET_RESET[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i < CFG_OFFSET_BASE) begin
        gain_q[cfg_index_i[1:0]] <= cfg_data_i[GAIN_W-1:0];
      end else if (cfg_index_i < CFG_END) begin
        offset_q[cfg_index_i[1:0]] <= cfg_data_i[OFFSET_W-1:0];
      end
    end
  end

  // request capture and product stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(item_q.adc_sample) * PROD_W'(gain_q[item_q.channel]);
    end
  end

  assign acc      = ACC_W'(prod_q) + ACC_W'(offset_q[item_q.channel]);
  assign acc_sh   = acc >> GAIN_SHIFT;
  assign clamp_lo = (item_q.value < lo) ? lo : item_q.value;
  assign clamp    = (clamp_lo > up) ? up : clamp_lo;
  assign cnt_inc  = (cnt_q == CNT_IDLE) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    cnt_d     = cnt_q;
    relay_d   = relay_q;
    pulse_d   = pulse_q;
    wr_lower  = 1'b0;
    wr_upper  = 1'b0;
    wr_target = 1'b0;
    wr_meas   = 1'b0;
    rd_d      = POS_MIN;
    if (item_q.op == OP_TICK) begin
      cnt_d = cnt_inc;
      priority if (cnt_inc < ON_TICKS) begin
        relay_d = 1'b0;
        pulse_d = 1'b1;
      end else if (cnt_inc > OFF_TICKS) begin
        relay_d = 1'b0;
      end else begin
        relay_d = 1'b1;
        pulse_d = 1'b0;
      end
    end else if (present) begin
      unique case (item_q.op)
        OP_SET_UPPER: wr_upper = item_q.value > lo;
        OP_SET_LOWER: wr_lower = item_q.value < up;
        OP_SET_POS: begin
          if (lo != POS_MIN && up != POS_MAX) begin
            wr_target = 1'b1;
            cnt_d     = '0;
          end
        end
        OP_ADC:      wr_meas = (cnt_q < ON_TICKS) || (cnt_q > ADC_LATE);
        OP_READ_POS: rd_d = (cnt_q < ADC_LATE) ? target_q[ch_idx] : measured_q[ch_idx];
        OP_READ_ADC: rd_d = measured_q[ch_idx];
        default:     rd_d = POS_MIN;
      endcase
    end
  end

  // commit state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lower_q[i]    <= POS_MIN;
        upper_q[i]    <= POS_MAX;
        target_q[i]   <= POS_MIN;
        measured_q[i] <= POS_MIN;
      end
      cnt_q   <= CNT_IDLE;
      relay_q <= 1'b0;
      pulse_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (wr_lower)  lower_q[ch_idx]    <= item_q.value;
      if (wr_upper)  upper_q[ch_idx]    <= item_q.value;
      if (wr_target) target_q[ch_idx]   <= clamp;
      if (wr_meas)   measured_q[ch_idx] <= acc_sh[POS_W-1:0];
      cnt_q   <= cnt_d;
      relay_q <= relay_d;
      pulse_q <= pulse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      result_q.read_data      <= rd_d;
      result_q.relay_on       <= relay_d;
      result_q.pulses_enabled <= pulse_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== src/servo_channel_register_block_unit.sv =====
// ----------------------------------------------------------------------------
// servo_channel_register_block_unit
// Multi-channel servo register block: limits, commanded and measured
// positions, relay window timing and per-channel converter calibration.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------
//  request   | start_i / busy_o          | item_i (op, channel, value, adc)
//  result    | result_valid_o (1 cycle)  | result_o (read_data, relay, pulse)
//  config    | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A request passes through capture, multiply of the converter sample by
// the channel gain, then commit of the channel state and the result register.
// The result strobe rises the cycle after commit; busy_o is low in that cycle,
// so the next request is taken while the result is shown.
// Reset (rst_ni low, asynchronous) loads the default limits, calibration and
// an idle relay counter. The receiver cannot stall the result.
//
module servo_channel_register_block_unit #(
  parameter int unsigned CHANNELS        = 4,
  parameter int unsigned RELAY_ON_TICKS  = 10,
  parameter int unsigned RELAY_OFF_TICKS = 100,
  parameter int unsigned GAIN_SHIFT      = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request
  input  logic                             start_i,
  output logic                             busy_o,
  input  svcrb_pkg::in_item_t              item_i,
  // result
  output logic                             result_valid_o,
  output svcrb_pkg::out_item_t             result_o,
  // configuration write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [svcrb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [svcrb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import svcrb_pkg::*;

  dp_cmd_t dp_cmd;

  // config writes land whenever offered
  assign cfg_ready_o = 1'b1;

  // sequence each request through capture, multiply and commit
  svcrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (result_valid_o),
    .cmd_o   (dp_cmd)
  );

  // hold channel state, relay timing and the result register
  svcrb_dpath #(
    .CHANNELS        (CHANNELS),
    .RELAY_ON_TICKS  (RELAY_ON_TICKS),
    .RELAY_OFF_TICKS (RELAY_OFF_TICKS),
    .GAIN_SHIFT      (GAIN_SHIFT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule

// ===== tb/svcrb_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcrb_tb_pkg
// Result scoreboard for the servo channel register block: tracks limits,
// positions, calibration and relay timing and checks each result in order.
// ----------------------------------------------------------------------------
package svcrb_tb_pkg;
  import svcrb_pkg::*;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned ON_TICKS     = 10;
  localparam int unsigned OFF_TICKS    = 100;
  localparam int unsigned SHIFT        = 11;
  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam int unsigned REPORT_CAP   = 40;

  class servo_result_scoreboard;
    logic [GAIN_W-1:0]   gain         [GAIN_REGS];
    logic [OFFSET_W-1:0] offset       [GAIN_REGS];
    logic [POS_W-1:0]    lower_lim    [NUM_CHANNELS];
    logic [POS_W-1:0]    upper_lim    [NUM_CHANNELS];
    logic [POS_W-1:0]    target_pos   [NUM_CHANNELS];
    logic [POS_W-1:0]    measured_pos [NUM_CHANNELS];
    logic [CNT_W-1:0]    relay_count;
    logic                relay_level;
    logic                pulse_en;
    out_item_t           pending_results [$];
    int unsigned         checked;
    int unsigned         mismatches;

    function new();
      for (int i = 0; i < GAIN_REGS; i++) begin
        gain[i]   = GAIN_RESET[i];
        offset[i] = OFFSET_RESET[i];
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        lower_lim[c]    = POS_MIN;
        upper_lim[c]    = POS_MAX;
        target_pos[c]   = '0;
        measured_pos[c] = '0;
      end
      relay_count = CNT_IDLE;
      relay_level = 1'b0;
      pulse_en    = 1'b0;
      checked     = 0;
      mismatches  = 0;
    endfunction

    // Unknown indexes fall through both branches and change nothing.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < CFG_OFFSET_BASE) begin
        gain[idx[1:0]] = data[GAIN_W-1:0];
      end else if (idx < CFG_END) begin
        offset[idx[1:0]] = data;
      end
    endfunction

    // Apply one accepted request to the state and queue its result.
    function void note_request(in_item_t req);
      logic [31:0]      acc;
      logic [POS_W-1:0] pos;
      out_item_t        res;
      res = '0;
      if (req.op == OP_TICK) begin
        if (relay_count != CNT_IDLE) relay_count++;
        if (relay_count < ON_TICKS) begin
          relay_level = 1'b0;
          pulse_en    = 1'b1;
        end else if (relay_count > OFF_TICKS) begin
          relay_level = 1'b0;
        end else begin
          relay_level = 1'b1;
          pulse_en    = 1'b0;
        end
      end else if (req.channel < NUM_CHANNELS) begin
        case (req.op)
          OP_SET_UPPER: begin
            if (req.value > lower_lim[req.channel]) upper_lim[req.channel] = req.value;
          end
          OP_SET_LOWER: begin
            if (req.value < upper_lim[req.channel]) lower_lim[req.channel] = req.value;
          end
          OP_SET_POS: begin
            if (lower_lim[req.channel] > POS_MIN && upper_lim[req.channel] < POS_MAX) begin
              pos = req.value;
              if (pos < lower_lim[req.channel]) pos = lower_lim[req.channel];
              if (pos > upper_lim[req.channel]) pos = upper_lim[req.channel];
              target_pos[req.channel] = pos;
              relay_count = '0;
            end
          end
          OP_ADC: begin
            if (relay_count < ON_TICKS || relay_count > OFF_TICKS + ADC_GUARD_TICKS) begin
              acc = 32'(req.adc_sample) * 32'(gain[req.channel]) + 32'(offset[req.channel]);
              measured_pos[req.channel] = acc[SHIFT +: POS_W];
            end
          end
          OP_READ_POS: begin
            res.read_data = (relay_count < OFF_TICKS + ADC_GUARD_TICKS) ?
                            target_pos[req.channel] : measured_pos[req.channel];
          end
          OP_READ_ADC: begin
            res.read_data = measured_pos[req.channel];
          end
          default: ;
        endcase
      end
      res.relay_on       = relay_level;
      res.pulses_enabled = pulse_en;
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatches < REPORT_CAP) begin
        $display("%0t: %s mismatch on result %0d: got 0x%0h, expected 0x%0h",
                 $time, what, checked, got, want);
      end
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got.read_data, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data != want.read_data)
        report_mismatch("read_data", got.read_data, want.read_data);
      if (got.relay_on != want.relay_on)
        report_mismatch("relay_on", got.relay_on, want.relay_on);
      if (got.pulses_enabled != want.pulses_enabled)
        report_mismatch("pulses_enabled", got.pulses_enabled, want.pulses_enabled);
      checked++;
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the servo channel register block with a directed opening and seven
// random phases, each after the first under its own calibration, and checks
// every result against the scoreboard's prediction in order of acceptance.
// ----------------------------------------------------------------------------
module testbench;
  import svcrb_pkg::*;
  import svcrb_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_ITEMS   = 190;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  busy_o;
  in_item_t              item_i      = '0;
  logic                  result_valid_o;
  out_item_t             result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  servo_result_scoreboard sb;
  int unsigned            burst_left = 0;
  int unsigned            cycle_count = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  servo_channel_register_block_unit #(
    .CHANNELS        (NUM_CHANNELS),
    .RELAY_ON_TICKS  (ON_TICKS),
    .RELAY_OFF_TICKS (OFF_TICKS),
    .GAIN_SHIFT      (SHIFT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Results cannot be held off: take every strobe at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // Watchdog: drop the run if it stalls far past the slowest correct pace.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_request(logic [2:0] op, logic [1:0] ch,
                                            logic [POS_W-1:0] value, logic [ADC_W-1:0] sample);
    in_item_t req;
    req.op         = op;
    req.channel    = ch;
    req.value      = value;
    req.adc_sample = sample;
    return req;
  endfunction

  // Bias values toward the ends of the range and toward the current limits,
  // so equal-to-limit rejects and clamps both get hit.
  function automatic logic [POS_W-1:0] pick_value(logic [1:0] ch);
    logic [POS_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = POS_MIN;
      1:       v = POS_MAX;
      2:       v = POS_W'($urandom_range(1, 3));
      3:       v = POS_MAX - POS_W'($urandom_range(1, 3));
      4:       v = sb.lower_lim[ch] + POS_W'($urandom_range(0, 2)) - 16'd1;
      5:       v = sb.upper_lim[ch] + POS_W'($urandom_range(0, 2)) - 16'd1;
      default: v = POS_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [ADC_W-1:0] pick_sample();
    logic [ADC_W-1:0] s;
    case ($urandom_range(0, 7))
      0:       s = '0;
      1:       s = '1;
      default: s = ADC_W'($urandom);
    endcase
    return s;
  endfunction

  // tick_pm and pos_pm set the per-mille share of ticks and position writes;
  // a low position share lets the relay counter run out to saturation.
  function automatic in_item_t random_request(int unsigned tick_pm, int unsigned pos_pm);
    in_item_t    req;
    int unsigned r;
    r              = $urandom_range(0, 999);
    req.channel    = 2'($urandom);
    req.value      = pick_value(req.channel);
    req.adc_sample = pick_sample();
    if (r < tick_pm) begin
      req.op = OP_TICK;
    end else if (r < tick_pm + pos_pm) begin
      req.op = OP_SET_POS;
    end else begin
      case (r % 8)
        0:       req.op = OP_SET_UPPER;
        1:       req.op = OP_SET_LOWER;
        2, 3:    req.op = OP_ADC;
        4, 6:    req.op = OP_READ_POS;
        5:       req.op = OP_READ_ADC;
        default: req.op = OP_UNUSED;
      endcase
    end
    return req;
  endfunction

  // Send one request. Between bursts lower start for a random gap; within a
  // burst hold start high so back-to-back requests meet the block as it frees.
  task automatic send_request(in_item_t req);
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
                                                  $urandom_range(1, 12);
    end
    burst_left--;
    start_i <= 1'b1;
    item_i  <= req;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(req);
  endtask

  // Hold valid across consecutive writes; the caller drops it once at the end.
  task automatic write_calibration(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
  endtask

  // Phase 1 drives every register to all ones, phase 2 to zero, the rest mix
  // extremes with random words. An out-of-map index is written every time.
  task automatic program_calibration(int unsigned phase);
    logic [CFG_DATA_W-1:0] data;
    for (int unsigned idx = 0; idx < CFG_END; idx++) begin
      if (phase == 1) begin
        data = '1;
      end else if (phase == 2) begin
        data = '0;
      end else begin
        case ($urandom_range(0, 5))
          0:       data = '0;
          1:       data = '1;
          default: data = CFG_DATA_W'($urandom);
        endcase
      end
      write_calibration(CFG_IDX_W'(idx), data);
    end
    write_calibration(CFG_IDX_W'($urandom_range(CFG_END, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned tick_pm;
    int unsigned pos_pm;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening under reset calibration.
    // Idle counter: a read of the position returns the measured value.
    send_request(make_request(OP_READ_POS,  2'd0, 16'h0000, 10'h000));
    // Position write with limits still at their defaults is refused.
    send_request(make_request(OP_SET_POS,   2'd0, 16'h1234, 10'h000));
    send_request(make_request(OP_ADC,       2'd0, 16'h0000, 10'h3FF));
    send_request(make_request(OP_READ_ADC,  2'd0, 16'h0000, 10'h000));
    send_request(make_request(OP_READ_POS,  2'd0, 16'h0000, 10'h000));
    // Limit writes that would break lower < upper are refused.
    send_request(make_request(OP_SET_UPPER, 2'd1, 16'h0000, 10'h000));
    send_request(make_request(OP_SET_LOWER, 2'd1, 16'hFFFF, 10'h000));
    send_request(make_request(OP_SET_LOWER, 2'd1, 16'd100,  10'h000));
    send_request(make_request(OP_SET_UPPER, 2'd1, 16'd100,  10'h000));
    // Upper still at its default: position write refused.
    send_request(make_request(OP_SET_POS,   2'd1, 16'h2000, 10'h000));
    send_request(make_request(OP_SET_UPPER, 2'd1, 16'd5000, 10'h000));
    // Clamp up to the lower limit; relay bits only move on the next tick.
    send_request(make_request(OP_SET_POS,   2'd1, 16'h0000, 10'h000));
    send_request(make_request(OP_READ_POS,  2'd1, 16'h0000, 10'h000));
    send_request(make_request(OP_TICK,      2'd0, 16'h0000, 10'h000));
    send_request(make_request(OP_ADC,       2'd1, 16'h0000, 10'h000));
    send_request(make_request(OP_READ_ADC,  2'd1, 16'h0000, 10'h000));
    // Clamp down to the upper limit.
    send_request(make_request(OP_SET_POS,   2'd1, 16'hFFFF, 10'h000));
    // Unused op code changes nothing.
    send_request(make_request(OP_UNUSED,    2'd3, 16'hFFFF, 10'h3FF));
    send_request(make_request(OP_SET_LOWER, 2'd2, 16'h0001, 10'h000));
    send_request(make_request(OP_SET_UPPER, 2'd2, 16'hFFFE, 10'h000));
    send_request(make_request(OP_SET_POS,   2'd2, 16'h8000, 10'h000));
    send_request(make_request(OP_TICK,      2'd3, 16'hFFFF, 10'h3FF));
    send_request(make_request(OP_READ_POS,  2'd2, 16'h0000, 10'h000));
    send_request(make_request(OP_SET_LOWER, 2'd3, 16'h0000, 10'h000));
    send_request(make_request(OP_ADC,       2'd3, 16'h0000, 10'h155));
    start_i <= 1'b0;
    wait_drained();

    // Random phases. Each opens with a limit setup per channel so position
    // writes get through, then runs a mix tuned to its own relay pace.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) program_calibration(phase);
      for (int unsigned ch = 0; ch < NUM_CHANNELS; ch++) begin
        send_request(make_request(OP_SET_UPPER, 2'(ch),
                                  POS_W'($urandom_range(16'h8000, 16'hFFFE)), pick_sample()));
        send_request(make_request(OP_SET_LOWER, 2'(ch),
                                  POS_W'($urandom_range(16'h0001, 16'h7FFF)), pick_sample()));
      end
      tick_pm = $urandom_range(350, 700);
      case (phase % 3)
        0:       pos_pm = 3;
        1:       pos_pm = 15;
        default: pos_pm = 60;
      endcase
      repeat (PHASE_ITEMS) send_request(random_request(tick_pm, pos_pm));
      start_i <= 1'b0;
      wait_drained();
    end

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
